// ----- hw/rtl/disp_pkg.sv -----
// ----------------------------------------------------------------------------
// Display init sequence player package
// Shared action codes and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package disp_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned ActW  = 2;

    localparam logic [ActW-1:0] ACT_CMD   = 2'd0;
    localparam logic [ActW-1:0] ACT_DATA  = 2'd1;
    localparam logic [ActW-1:0] ACT_DELAY = 2'd2;
    localparam logic [ActW-1:0] ACT_END   = 2'd3;

    localparam logic [ByteW-1:0] END_BYTE   = 8'h00;
    localparam logic [ByteW-1:0] DELAY_MARK = 8'hFF;

    typedef struct packed {
        logic [ActW-1:0]  action;
        logic [ByteW-1:0] out_value;
        logic             dc_level;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/display_init_sequence_player_top.sv -----
// ----------------------------------------------------------------------------
// Display init sequence player
// Interprets a display init command table streamed one byte per word.
// ----------------------------------------------------------------------------
// Each table byte is registered, decoded against the current table position
// and, when it yields an action, written to the result register, so the block
// accepts one byte per clock cycle when not stalled, and a result word passes
// through the input register and then the result register. The only stall
// comes from a full result register that the consumer is not draining. Count
// bytes and every byte after the end marker produce no result word; after the
// end marker the block keeps accepting and discarding bytes until reset.
`default_nettype none

module display_init_sequence_player_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_seq_valid,
    output logic                            o_seq_ready,
    input  wire logic [disp_pkg::ByteW-1:0] i_seq_byte,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output logic [disp_pkg::ActW-1:0]       o_action,
    output logic [disp_pkg::ByteW-1:0]      o_out_value,
    output logic                            o_dc_level
);
    import disp_pkg::*;

    logic             in_valid;
    logic [ByteW-1:0] in_byte;
    logic             emit;
    logic             out_free;
    logic             advance;
    t_result          dec_result;
    t_result          out_result;

    // A byte without a result never waits on the result register.
    assign advance = in_valid && (!emit || out_free);

    disp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_seq_valid),
        .o_ready (o_seq_ready),
        .i_byte  (i_seq_byte),
        .i_take  (advance),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    disp_decode u_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (in_byte),
        .i_advance (advance),
        .o_emit    (emit),
        .o_result  (dec_result)
    );

    disp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (dec_result),
        .o_free   (out_free),
        .o_valid  (o_res_valid),
        .i_ready  (i_res_ready),
        .o_result (out_result)
    );

    assign o_action    = out_result.action;
    assign o_out_value = out_result.out_value;
    assign o_dc_level  = out_result.dc_level;

endmodule

`default_nettype wire

// ----- hw/rtl/disp_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one table byte until the decoder consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module disp_in_stage (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [disp_pkg::ByteW-1:0] i_byte,
    input  wire logic                       i_take,
    output logic                            o_valid,
    output logic [disp_pkg::ByteW-1:0]      o_byte
);
    import disp_pkg::*;

    logic             r_valid;
    logic             n_valid;
    logic [ByteW-1:0] r_byte;
    logic             load;

    // A word can enter in the same cycle the held one is consumed.
    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// ----- hw/rtl/disp_decode.sv -----
// ----------------------------------------------------------------------------
// Table decoder
// Tracks the position in the init table and turns each byte into an action.
// ----------------------------------------------------------------------------
`default_nettype none

module disp_decode (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [disp_pkg::ByteW-1:0] i_byte,
    input  wire logic                       i_advance,
    output logic                            o_emit,
    output disp_pkg::t_result               o_result
);
    import disp_pkg::*;

    localparam logic [2:0] PH_CMD   = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_DELAY = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    logic [2:0]       r_phase;
    logic [2:0]       n_phase;
    logic [ByteW-1:0] r_left;
    logic [ByteW-1:0] n_left;
    logic [ByteW-1:0] left_dec;

    assign left_dec = r_left - 1'b1;

    always_comb begin
        n_phase            = r_phase;
        n_left             = r_left;
        o_emit             = 1'b0;
        o_result.action    = ACT_CMD;
        o_result.out_value = i_byte;
        o_result.dc_level  = 1'b0;
        case (r_phase)
            PH_DONE: begin
                o_emit = 1'b0;
            end
            PH_COUNT: begin
                if (i_byte == DELAY_MARK) begin
                    n_phase = PH_DELAY;
                end else if (i_byte == END_BYTE) begin
                    n_phase = PH_CMD;
                end else begin
                    n_left  = i_byte;
                    n_phase = PH_DATA;
                end
            end
            PH_DELAY: begin
                o_emit          = 1'b1;
                o_result.action = ACT_DELAY;
                n_phase         = PH_CMD;
            end
            PH_DATA: begin
                o_emit            = 1'b1;
                o_result.action   = ACT_DATA;
                o_result.dc_level = 1'b1;
                n_left            = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_CMD;
                end
            end
            default: begin
                // Unused phase codes behave as the command position.
                o_emit = 1'b1;
                if (i_byte == END_BYTE) begin
                    o_result.action    = ACT_END;
                    o_result.out_value = '0;
                    n_phase            = PH_DONE;
                end else begin
                    n_phase = PH_COUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_left  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/disp_out_stage.sv -----
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded action until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module disp_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire disp_pkg::t_result i_result,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output disp_pkg::t_result      o_result
);
    import disp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
